### sv/wav_header_parser_unit_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef WAV_HEADER_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WAVHP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wavhp check failed");

// Next-cycle implication, disabled during reset.
`define WAVHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wavhp check failed");

`endif

### sv/wavhp_pkg.sv
`timescale 1ns / 1ps
package wavhp_pkg;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
   localparam logic [2:0] ERR_NOT_PCM   = 3'd2;
   localparam logic [2:0] ERR_FMT_SHORT = 3'd3;
   localparam logic [2:0] ERR_INVALID   = 3'd4;

   localparam logic [2:0] PH_RIFF  = 3'd0;
   localparam logic [2:0] PH_CHUNK = 3'd1;
   localparam logic [2:0] PH_FMT   = 3'd2;
   localparam logic [2:0] PH_SKIP  = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FMT_PCM = 16'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  error_code;
      logic [31:0] data_start;
      logic [31:0] data_size;
      logic [31:0] sample_rate;
      logic [1:0]  channel_count;
      logic [4:0]  sample_bits;
   } result_type;

endpackage

### sv/wavhp_in_stage.sv
`timescale 1ns / 1ps
module wavhp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first,
   input  logic                req_last,
   input  logic                adv,
   output logic                item_valid,
   output wavhp_pkg::item_type item
);

   logic                item_valid_ff;
   logic                item_valid_in;
   wavhp_pkg::item_type item_ff;
   logic                take;

   // holds a word until the core consumes it
   assign req_stall = item_valid_ff && !adv;
   assign take      = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (adv) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte <= req_data_byte;
         item_ff.first     <= req_first;
         item_ff.last      <= req_last;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

### sv/wavhp_core.sv
`timescale 1ns / 1ps
module wavhp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  wavhp_pkg::item_type   item,
   output logic                  res_valid,
   output wavhp_pkg::result_type res
);

   logic [2:0]  phase_ff,    phase_in,    cur_phase;
   logic [31:0] offset_ff,   offset_in,   cur_offset;
   logic [3:0]  fc_ff,       fc_in,       cur_fc;
   logic [31:0] tag_ff,      tag_in,      cur_tag;
   logic [31:0] len_ff,      len_in,      cur_len;
   logic [32:0] skip_ff,     skip_in,     cur_skip;
   logic        fseen_ff,    fseen_in,    cur_fseen;
   logic [15:0] fmt_ff,      fmt_in,      cur_fmt;
   logic [15:0] ch_ff,       ch_in,       cur_ch;
   logic [31:0] rate_ff,     rate_in,     cur_rate;
   logic [15:0] bits_ff,     bits_in,     cur_bits;
   logic        finished_ff, finished_in, cur_finished;

   logic [7:0]  b;
   logic [31:0] tag_shift;
   logic [4:0]  flen;
   logic [32:0] skip_dec;
   logic        rep;
   logic [2:0]  err;
   logic        hdr_good;

   function automatic logic [4:0] fmt_len(input logic [31:0] len);
      fmt_len = (len > 32'd16) ? 5'd16 : len[4:0];
   endfunction

   always_comb begin
      // a first word restarts from the reset state
      if (item.first) begin
         cur_phase    = wavhp_pkg::PH_RIFF;
         cur_offset   = '0;
         cur_fc       = '0;
         cur_tag      = '0;
         cur_len      = '0;
         cur_skip     = '0;
         cur_fseen    = 1'b0;
         cur_fmt      = '0;
         cur_ch       = '0;
         cur_rate     = '0;
         cur_bits     = '0;
         cur_finished = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_offset   = offset_ff;
         cur_fc       = fc_ff;
         cur_tag      = tag_ff;
         cur_len      = len_ff;
         cur_skip     = skip_ff;
         cur_fseen    = fseen_ff;
         cur_fmt      = fmt_ff;
         cur_ch       = ch_ff;
         cur_rate     = rate_ff;
         cur_bits     = bits_ff;
         cur_finished = finished_ff;
      end

      phase_in    = cur_phase;
      offset_in   = cur_offset;
      fc_in       = cur_fc;
      tag_in      = cur_tag;
      len_in      = cur_len;
      skip_in     = cur_skip;
      fseen_in    = cur_fseen;
      fmt_in      = cur_fmt;
      ch_in       = cur_ch;
      rate_in     = cur_rate;
      bits_in     = cur_bits;
      finished_in = cur_finished;

      b         = item.data_byte;
      tag_shift = {cur_tag[23:0], b};
      flen      = fmt_len(cur_len);
      skip_dec  = cur_skip - 33'd1;
      hdr_good  = 1'b0;
      rep       = 1'b0;
      err       = wavhp_pkg::ERR_NONE;
      res       = '0;

      if (!cur_finished) begin
         case (cur_phase)
            wavhp_pkg::PH_RIFF: begin
               tag_in = tag_shift;
               if (cur_fc == 4'd3 && tag_shift != wavhp_pkg::TAG_RIFF) begin
                  rep = 1'b1;
                  err = wavhp_pkg::ERR_NOT_WAVE;
               end else if (cur_fc >= 4'd11) begin
                  if (tag_shift != wavhp_pkg::TAG_WAVE) begin
                     rep = 1'b1;
                     err = wavhp_pkg::ERR_NOT_WAVE;
                  end else begin
                     phase_in = wavhp_pkg::PH_CHUNK;
                     fc_in    = '0;
                  end
               end else begin
                  fc_in = cur_fc + 4'd1;
               end
            end
            wavhp_pkg::PH_CHUNK: begin
               case (cur_fc)
                  4'd0, 4'd1, 4'd2, 4'd3: tag_in = tag_shift;
                  4'd4:    len_in = {24'd0, b};
                  4'd5:    len_in = cur_len | {16'd0, b, 8'd0};
                  4'd6:    len_in = cur_len | {8'd0, b, 16'd0};
                  default: len_in = cur_len | {b, 24'd0};
               endcase
               if (cur_fc >= 4'd7) begin
                  fc_in = '0;
                  if (tag_in == wavhp_pkg::TAG_FMT) begin
                     fmt_in  = '0;
                     ch_in   = '0;
                     rate_in = '0;
                     bits_in = '0;
                     if (len_in == 32'd0) begin
                        // empty fmt body reads as format zero
                        rep = 1'b1;
                        err = wavhp_pkg::ERR_NOT_PCM;
                     end else begin
                        phase_in = wavhp_pkg::PH_FMT;
                     end
                  end else if (tag_in == wavhp_pkg::TAG_DATA) begin
                     rep      = 1'b1;
                     hdr_good = cur_fseen && (len_in != 32'd0) &&
                                (cur_ch == 16'd1 || cur_ch == 16'd2) &&
                                (cur_bits == 16'd8 || cur_bits == 16'd16);
                     err      = hdr_good ? wavhp_pkg::ERR_NONE : wavhp_pkg::ERR_INVALID;
                     res.data_start    = cur_offset + 32'd1;
                     res.data_size     = len_in;
                     res.sample_rate   = cur_rate;
                     res.channel_count = cur_ch[1:0];
                     res.sample_bits   = cur_bits[4:0];
                  end else begin
                     skip_in  = {1'b0, len_in} + {32'd0, len_in[0]};
                     phase_in = (skip_in != 33'd0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_CHUNK;
                  end
               end else begin
                  fc_in = cur_fc + 4'd1;
               end
            end
            wavhp_pkg::PH_FMT: begin
               case (cur_fc)
                  4'd0:    fmt_in  = {8'd0, b};
                  4'd1:    fmt_in  = cur_fmt | {b, 8'd0};
                  4'd2:    ch_in   = {8'd0, b};
                  4'd3:    ch_in   = cur_ch | {b, 8'd0};
                  4'd4:    rate_in = {24'd0, b};
                  4'd5:    rate_in = cur_rate | {16'd0, b, 8'd0};
                  4'd6:    rate_in = cur_rate | {8'd0, b, 16'd0};
                  4'd7:    rate_in = cur_rate | {b, 24'd0};
                  4'd14:   bits_in = {8'd0, b};
                  4'd15:   bits_in = cur_bits | {b, 8'd0};
                  default: ;
               endcase
               if (({1'b0, cur_fc} + 5'd1) >= flen) begin
                  if (fmt_in != wavhp_pkg::FMT_PCM) begin
                     rep = 1'b1;
                     err = wavhp_pkg::ERR_NOT_PCM;
                  end else begin
                     fseen_in = 1'b1;
                     fc_in    = '0;
                     // rest of the body plus the pad byte of an odd size
                     skip_in  = ({1'b0, cur_len} - {28'd0, flen}) + {32'd0, cur_len[0]};
                     phase_in = (skip_in != 33'd0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_CHUNK;
                  end
               end else begin
                  fc_in = cur_fc + 4'd1;
               end
            end
            wavhp_pkg::PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 33'd0) begin
                  phase_in = wavhp_pkg::PH_CHUNK;
                  fc_in    = '0;
               end
            end
            default: ;
         endcase

         offset_in = cur_offset + 32'd1;

         if (!rep && item.last) begin
            rep = 1'b1;
            if (phase_in == wavhp_pkg::PH_RIFF) begin
               err = wavhp_pkg::ERR_NOT_WAVE;
            end else if (phase_in == wavhp_pkg::PH_FMT) begin
               err = wavhp_pkg::ERR_FMT_SHORT;
            end else begin
               // end of stream without data chunk: size zero never validates
               err = wavhp_pkg::ERR_INVALID;
            end
         end

         if (rep) begin
            finished_in = 1'b1;
            phase_in    = wavhp_pkg::PH_DONE;
         end
      end

      res.error_code = err;
      res.ok         = rep && (err == wavhp_pkg::ERR_NONE);
      if (!res.ok) begin
         res.data_start    = '0;
         res.data_size     = '0;
         res.sample_rate   = '0;
         res.channel_count = '0;
         res.sample_bits   = '0;
      end
      res_valid = rep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wavhp_pkg::PH_RIFF;
         offset_ff   <= '0;
         fc_ff       <= '0;
         tag_ff      <= '0;
         len_ff      <= '0;
         skip_ff     <= '0;
         fseen_ff    <= 1'b0;
         fmt_ff      <= '0;
         ch_ff       <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         finished_ff <= 1'b0;
      end else if (adv) begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         fc_ff       <= fc_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         fseen_ff    <= fseen_in;
         fmt_ff      <= fmt_in;
         ch_ff       <= ch_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         finished_ff <= finished_in;
      end
   end

endmodule

### sv/wavhp_out_stage.sv
`timescale 1ns / 1ps
module wavhp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic                  res_valid,
   input  wavhp_pkg::result_type res,
   output logic                  adv,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [2:0]            rsp_error_code,
   output logic [31:0]           rsp_data_start,
   output logic [31:0]           rsp_data_size,
   output logic [31:0]           rsp_sample_rate,
   output logic [1:0]            rsp_channel_count,
   output logic [4:0]            rsp_sample_bits
);

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   wavhp_pkg::result_type rsp_ff;

   // the core steps when an item is held and the result slot is empty or draining this cycle
   assign adv = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ff.ok;
   assign rsp_error_code    = rsp_ff.error_code;
   assign rsp_data_start    = rsp_ff.data_start;
   assign rsp_data_size     = rsp_ff.data_size;
   assign rsp_sample_rate   = rsp_ff.sample_rate;
   assign rsp_channel_count = rsp_ff.channel_count;
   assign rsp_sample_bits   = rsp_ff.sample_bits;

endmodule

### sv/wav_header_parser_unit.sv
// A result word is formed from the byte in the input register and stored in the
// result register when the core steps. Throughput: 1 byte per cycle unless a held
// result is stalled; the parse state updates once per byte. The input and result
// registers decouple the two channels. Reset (synchronous, active high) empties
// both registers and returns the parser to the RIFF tag phase with all fields zero.
`timescale 1ns / 1ps
module wav_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_data_start,
   output logic [31:0] rsp_data_size,
   output logic [31:0] rsp_sample_rate,
   output logic [1:0]  rsp_channel_count,
   output logic [4:0]  rsp_sample_bits
);

   logic                  adv;
   logic                  item_valid;
   wavhp_pkg::item_type   item;
   logic                  res_valid;
   wavhp_pkg::result_type res;

   wavhp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_first     (req_first),
      .req_last      (req_last),
      .adv           (adv),
      .item_valid    (item_valid),
      .item          (item)
   );

   wavhp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   wavhp_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .res_valid         (res_valid),
      .res               (res),
      .adv               (adv),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_error_code    (rsp_error_code),
      .rsp_data_start    (rsp_data_start),
      .rsp_data_size     (rsp_data_size),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_bits   (rsp_sample_bits)
   );

endmodule

### sv/wavhp_checker.sv
`timescale 1ns / 1ps
`include "wav_header_parser_unit_macros.svh"
module wavhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_first,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_ok,
   input logic [2:0]  rsp_error_code,
   input logic [31:0] rsp_data_start,
   input logic [31:0] rsp_data_size,
   input logic [31:0] rsp_sample_rate,
   input logic [1:0]  rsp_channel_count,
   input logic [4:0]  rsp_sample_bits
);

   logic         bad_fields_zero;
   logic         good_fields_sane;
   logic         err_known;
   logic         req_held;
   logic         rsp_held;
   logic [9:0]   req_word;
   logic [106:0] rsp_word;

   assign bad_fields_zero = (rsp_data_start == 32'd0) && (rsp_data_size == 32'd0) &&
                            (rsp_sample_rate == 32'd0) && (rsp_channel_count == 2'd0) &&
                            (rsp_sample_bits == 5'd0);
   assign good_fields_sane = (rsp_error_code == wavhp_pkg::ERR_NONE) &&
                             (rsp_data_size != 32'd0) &&
                             (rsp_channel_count == 2'd1 || rsp_channel_count == 2'd2) &&
                             (rsp_sample_bits == 5'd8 || rsp_sample_bits == 5'd16);
   assign err_known = (rsp_error_code == wavhp_pkg::ERR_NOT_WAVE) ||
                      (rsp_error_code == wavhp_pkg::ERR_NOT_PCM) ||
                      (rsp_error_code == wavhp_pkg::ERR_FMT_SHORT) ||
                      (rsp_error_code == wavhp_pkg::ERR_INVALID);

   assign req_held = req_valid && req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign req_word = {req_data_byte, req_first, req_last};
   assign rsp_word = {rsp_ok, rsp_error_code, rsp_data_start, rsp_data_size,
                      rsp_sample_rate, rsp_channel_count, rsp_sample_bits};

   `WAVHP_ASSERT_NOW(a_err_zeroes, clock, reset, rsp_valid && !rsp_ok, bad_fields_zero)
   `WAVHP_ASSERT_NOW(a_ok_sane, clock, reset, rsp_valid && rsp_ok, good_fields_sane)
   `WAVHP_ASSERT_NOW(a_err_code, clock, reset, rsp_valid && !rsp_ok, err_known)
   `WAVHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))
   `WAVHP_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_word))

endmodule

bind wav_header_parser_unit wavhp_checker u_wavhp_checker (.*);
